// ----- sv/mpbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mpbf_pkg
// Shared types and constants for the multi-pipe byte FIFO: command and status
// codes, field widths, and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package mpbf_pkg;

  localparam int CMD_W    = 2;
  localparam int PID_W    = 3;
  localparam int DATA_W   = 8;
  localparam int CNT_W    = 7;
  localparam int STAT_W   = 3;
  localparam int FILL_W   = 10;
  localparam int PID_SPAN = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOFREE = 3'd3,
    ST_CLOSED = 3'd4
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch_in;     // capture the accepted command
    logic exec_single;  // run a single-result command and load the result
    logic rd_start;     // load the read byte budget
    logic rd_issue;     // read one byte from the store, advance read pointer
    logic rd_emit;      // load a popped byte into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rd_go;        // latched command is a read with bytes to return
    logic rem_last;     // one byte left in the current read
    logic out_free;     // output register can take a new result this cycle
  } dp_stat_t;

endpackage

// ----- sv/mpbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpbf_ctrl
// Sequencer for the multi-pipe byte FIFO: accepts one command at a time and
// steps the datapath through execute, byte fetch and byte emit.
// ----------------------------------------------------------------------------
module mpbf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpbf_pkg::dp_stat_t stat_i,
  output mpbf_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DATA
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.rd_go) begin
          cmd_o.rd_start = 1'b1;
          state_d        = S_POP;
        end else if (stat_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_DATA;
      end
      S_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.rd_emit = 1'b1;
          state_d       = stat_i.rem_last ? S_IDLE : S_POP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- sv/mpbf_dp.sv -----
// ----------------------------------------------------------------------------
// mpbf_dp
// Datapath of the multi-pipe byte FIFO: pipe pointers, reference counts,
// shared byte store and the registered output stage.
// ----------------------------------------------------------------------------
module mpbf_dp #(
  parameter int PIPE_COUNT = 8,
  parameter int PIPE_BYTES = 512,
  parameter int MAX_READ   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpbf_pkg::dp_cmd_t             cmd_i,
  output mpbf_pkg::dp_stat_t            stat_o,
  input  logic [mpbf_pkg::CMD_W-1:0]    cmd_in_i,
  input  logic [mpbf_pkg::PID_W-1:0]    pipe_id_i,
  input  logic [mpbf_pkg::DATA_W-1:0]   data_i,
  input  logic [mpbf_pkg::CNT_W-1:0]    count_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [mpbf_pkg::STAT_W-1:0]   status_o,
  output logic [mpbf_pkg::PID_W-1:0]    pipe_num_o,
  output logic [mpbf_pkg::DATA_W-1:0]   byte_out_o,
  output logic [mpbf_pkg::FILL_W-1:0]   fill_level_o,
  output logic                          last_o
);

  // Only pipes a 3-bit id can name are ever built.
  localparam int NP        = (PIPE_COUNT < mpbf_pkg::PID_SPAN) ? PIPE_COUNT
                                                               : mpbf_pkg::PID_SPAN;
  localparam int IDX_W     = (NP > 1) ? $clog2(NP) : 1;
  localparam int SPAN      = 2 * PIPE_BYTES;
  localparam int PTR_W     = $clog2(SPAN);
  localparam int OFF_W     = $clog2(PIPE_BYTES);
  localparam int MEM_DEPTH = NP * PIPE_BYTES;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CW        = (PTR_W > mpbf_pkg::CNT_W) ? PTR_W : mpbf_pkg::CNT_W;

  // Latched command
  mpbf_pkg::cmd_e              cmd_q;
  logic [mpbf_pkg::PID_W-1:0]  pid_q;
  logic [mpbf_pkg::DATA_W-1:0] data_q;
  logic [mpbf_pkg::CNT_W-1:0]  cnt_q;

  // Per-pipe state
  logic [PTR_W-1:0] rp_q [NP];
  logic [PTR_W-1:0] wp_q [NP];
  logic [1:0]       rc_q [NP];

  logic [7:0]                  mem_q [MEM_DEPTH];
  logic [mpbf_pkg::DATA_W-1:0] rd_data_q;
  logic [mpbf_pkg::CNT_W-1:0]  rem_q;

  // Output register
  logic                        out_valid_q;
  mpbf_pkg::status_e           out_status_q;
  logic [mpbf_pkg::PID_W-1:0]  out_pipe_q;
  logic [mpbf_pkg::DATA_W-1:0] out_byte_q;
  logic [PTR_W-1:0]            out_fill_q;
  logic                        out_last_q;

  logic [IDX_W-1:0]   idx;
  logic               pid_ok;
  logic [PTR_W-1:0]   rp, wp;
  logic [PTR_W:0]     diff;
  logic [PTR_W-1:0]   fill;
  logic               full;
  logic [PTR_W-1:0]   rp_next, wp_next;
  logic [PTR_W-1:0]   rd_off_p, wr_off_p;
  logic [OFF_W-1:0]   rd_off, wr_off;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               free_found;
  logic [mpbf_pkg::PID_W-1:0] free_idx;
  logic [mpbf_pkg::CNT_W-1:0] eff_cnt;
  logic [CW-1:0]      fill_x, eff_x, n_x;
  logic               out_free;
  logic               wr_ok;
  logic [PTR_W+mpbf_pkg::FILL_W-1:0] fill_ext;

  assign idx    = pid_q[IDX_W-1:0];
  assign pid_ok = ({{(mpbf_pkg::CNT_W-mpbf_pkg::PID_W){1'b0}}, pid_q}
                   < mpbf_pkg::CNT_W'(PIPE_COUNT));
  assign rp     = rp_q[idx];
  assign wp     = wp_q[idx];

  // Fill: write minus read modulo the pointer span.
  assign diff = {1'b0, wp} - {1'b0, rp};
  assign fill = diff[PTR_W] ? PTR_W'(diff + (PTR_W+1)'(SPAN)) : diff[PTR_W-1:0];
  assign full = (fill >= PTR_W'(PIPE_BYTES));

  assign rp_next = (rp == PTR_W'(SPAN - 1)) ? '0 : rp + 1'b1;
  assign wp_next = (wp == PTR_W'(SPAN - 1)) ? '0 : wp + 1'b1;

  // Fold the free-running pointer onto a store slot.
  assign rd_off_p = (rp >= PTR_W'(PIPE_BYTES)) ? rp - PTR_W'(PIPE_BYTES) : rp;
  assign wr_off_p = (wp >= PTR_W'(PIPE_BYTES)) ? wp - PTR_W'(PIPE_BYTES) : wp;
  assign rd_off   = rd_off_p[OFF_W-1:0];
  assign wr_off   = wr_off_p[OFF_W-1:0];
  assign rd_addr  = AW'(AW'(idx) * AW'(PIPE_BYTES)) + AW'(rd_off);
  assign wr_addr  = AW'(AW'(idx) * AW'(PIPE_BYTES)) + AW'(wr_off);

  // Lowest free pipe.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (rc_q[i] == 2'd0) begin
        free_found = 1'b1;
        free_idx   = mpbf_pkg::PID_W'(i);
      end
    end
  end

  // Read budget: zero counts as one, clamp to the read limit, then to the fill.
  always_comb begin
    if (cnt_q == '0) begin
      eff_cnt = mpbf_pkg::CNT_W'(1);
    end else if (cnt_q > mpbf_pkg::CNT_W'(MAX_READ)) begin
      eff_cnt = mpbf_pkg::CNT_W'(MAX_READ);
    end else begin
      eff_cnt = cnt_q;
    end
  end

  assign fill_x = CW'(fill);
  assign eff_x  = CW'(eff_cnt);
  assign n_x    = (fill_x < eff_x) ? fill_x : eff_x;

  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_ok    = cmd_i.exec_single && (cmd_q == mpbf_pkg::CMD_WRITE) && pid_ok && !full;

  assign stat_o.rd_go    = (cmd_q == mpbf_pkg::CMD_READ) && pid_ok && (fill != '0);
  assign stat_o.rem_last = (rem_q == mpbf_pkg::CNT_W'(1));
  assign stat_o.out_free = out_free;

  // Command capture, byte store and read counter: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q  <= mpbf_pkg::cmd_e'(cmd_in_i);
      pid_q  <= pipe_id_i;
      data_q <= data_i;
      cnt_q  <= count_i;
    end
    if (wr_ok) begin
      mem_q[wr_addr] <= data_q;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.rd_start) begin
      rem_q <= mpbf_pkg::CNT_W'(n_x);
    end else if (cmd_i.rd_emit) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  // Pipe pointers and reference counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        rp_q[i] <= '0;
        wp_q[i] <= '0;
        rc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec_single) begin
        case (cmd_q)
          mpbf_pkg::CMD_ALLOC: begin
            if (free_found) begin
              rc_q[free_idx[IDX_W-1:0]] <= 2'd2;
              rp_q[free_idx[IDX_W-1:0]] <= '0;
              wp_q[free_idx[IDX_W-1:0]] <= '0;
            end
          end
          mpbf_pkg::CMD_CLOSE: begin
            if (pid_ok && rc_q[idx] != 2'd0) begin
              rc_q[idx] <= rc_q[idx] - 1'b1;
            end
          end
          mpbf_pkg::CMD_WRITE: begin
            if (wr_ok) begin
              wp_q[idx] <= wp_next;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.rd_issue) begin
        rp_q[idx] <= rp_next;
      end
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_single || cmd_i.rd_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_emit) begin
      out_status_q <= mpbf_pkg::ST_OK;
      out_pipe_q   <= pid_q;
      out_byte_q   <= rd_data_q;
      out_fill_q   <= fill;
      out_last_q   <= (rem_q == mpbf_pkg::CNT_W'(1));
    end else if (cmd_i.exec_single) begin
      out_byte_q <= '0;
      out_last_q <= 1'b1;
      out_pipe_q <= pid_q;
      case (cmd_q)
        mpbf_pkg::CMD_ALLOC: begin
          out_status_q <= free_found ? mpbf_pkg::ST_OK : mpbf_pkg::ST_NOFREE;
          out_pipe_q   <= free_idx;
          out_fill_q   <= '0;
        end
        mpbf_pkg::CMD_CLOSE: begin
          out_status_q <= (pid_ok && rc_q[idx] != 2'd0) ? mpbf_pkg::ST_OK
                                                         : mpbf_pkg::ST_CLOSED;
          out_fill_q   <= pid_ok ? fill : '0;
        end
        mpbf_pkg::CMD_WRITE: begin
          out_status_q <= wr_ok ? mpbf_pkg::ST_OK : mpbf_pkg::ST_FULL;
          if (!pid_ok) begin
            out_fill_q <= '0;
          end else if (full) begin
            out_fill_q <= fill;
          end else begin
            out_fill_q <= fill + 1'b1;
          end
        end
        default: begin
          out_status_q <= mpbf_pkg::ST_EMPTY;
          out_fill_q   <= '0;
        end
      endcase
    end
  end

  assign fill_ext     = {{mpbf_pkg::FILL_W{1'b0}}, out_fill_q};
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pipe_num_o   = out_pipe_q;
  assign byte_out_o   = out_byte_q;
  assign fill_level_o = fill_ext[mpbf_pkg::FILL_W-1:0];
  assign last_o       = out_last_q;

endmodule

// ----- sv/multi_pipe_byte_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo
// A single result (allocate, close, write or an empty read) is registered from
//   the execute state once the output register is free. A read of n bytes
//   steps through the single registered store read port: each byte is fetched
//   from the store, then emitted into the output register once it is free.
//   The next command is taken only once the last result is loaded.
// A waiting result does not block the next command transfer until new output
//   is due. Reset frees every pipe and zeroes all pointers; store is not cleared.
// ----------------------------------------------------------------------------
module multi_pipe_byte_fifo #(
  parameter int PIPE_COUNT = 8,
  parameter int PIPE_BYTES = 512,
  parameter int MAX_READ   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpbf_pkg::CMD_W-1:0]    cmd_i,
  input  logic [mpbf_pkg::PID_W-1:0]    pipe_id_i,
  input  logic [mpbf_pkg::DATA_W-1:0]   data_i,
  input  logic [mpbf_pkg::CNT_W-1:0]    count_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpbf_pkg::STAT_W-1:0]   status_o,
  output logic [mpbf_pkg::PID_W-1:0]    pipe_num_o,
  output logic [mpbf_pkg::DATA_W-1:0]   byte_out_o,
  output logic [mpbf_pkg::FILL_W-1:0]   fill_level_o,
  output logic                          last_o
);

  // Command and status bundles between sequencer and datapath.
  mpbf_pkg::dp_cmd_t  dp_cmd;
  mpbf_pkg::dp_stat_t dp_stat;

  // Sequencer: take one command, run it, then step through the bytes of a read
  // (fetch from the store, emit into the output register) until the budget ends.
  mpbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath: per-pipe pointers and counts, shared byte store, result register.
  mpbf_dp #(
    .PIPE_COUNT (PIPE_COUNT),
    .PIPE_BYTES (PIPE_BYTES),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .cmd_in_i     (cmd_i),
    .pipe_id_i    (pipe_id_i),
    .data_i       (data_i),
    .count_i      (count_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .pipe_num_o   (pipe_num_o),
    .byte_out_o   (byte_out_o),
    .fill_level_o (fill_level_o),
    .last_o       (last_o)
  );

endmodule
